// ===== hw/rtl/bpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg: shared definitions of the bitmap page allocator
// Geometry, field widths, status codes, controller states and the helper
// functions used to initialise and search rows of the used-page bitmap.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int PAGE_COUNT     = 16384;
  localparam int PAGE_BYTES     = 4096;
  localparam int RESERVED_PAGES = 4096;

  // The bitmap is held as rows of ROW_BITS page bits.
  localparam int ROW_BITS   = 32;
  localparam int ROWS       = (PAGE_COUNT + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int BIT_W      = $clog2(ROW_BITS);
  localparam int PAGE_W     = ROW_W + BIT_W;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  localparam int RESERVED_CLIP = (RESERVED_PAGES > PAGE_COUNT) ? PAGE_COUNT : RESERVED_PAGES;
  localparam int HINT_ROW      = (RESERVED_CLIP / ROW_BITS > ROWS - 1) ? ROWS - 1
                                                                       : RESERVED_CLIP / ROW_BITS;

  localparam int IN_ADDR_W  = 32;
  localparam int OUT_ADDR_W = 26;
  localparam int COUNT_W    = 15;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADADDR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC,
    S_FREE
  } state_t;

  // Reset contents of one bitmap row: reserved pages and the pad bits past
  // the last page read as used.
  function automatic logic [ROW_BITS-1:0] init_row(input logic [ROW_W-1:0] r);
    logic [ROW_BITS-1:0] v;
    int                  page;
    v = '0;
    for (int b = 0; b < ROW_BITS; b++) begin
      page = int'(r) * ROW_BITS + b;
      v[b] = (page < RESERVED_CLIP) || (page >= PAGE_COUNT);
    end
    return v;
  endfunction

  // Index of the lowest clear bit; only meaningful when one exists.
  function automatic logic [BIT_W-1:0] first_zero(input logic [ROW_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (!w[b]) idx = BIT_W'(b);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bpa_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_if: request and result channels of the bitmap page allocator
// Valid/ready channels; an item moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface bpa_req_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [bpa_pkg::IN_ADDR_W-1:0]  page_address;

  modport source (output valid, output action, output page_address, input ready);
  modport sink   (input valid, input action, input page_address, output ready);
endinterface

interface bpa_rsp_if;
  logic                           valid;
  logic                           ready;
  bpa_pkg::status_t               status;
  logic [bpa_pkg::OUT_ADDR_W-1:0] allocated_address;
  logic [bpa_pkg::COUNT_W-1:0]    used_count;

  modport source (output valid, output status, output allocated_address,
                  output used_count, input ready);
  modport sink   (input valid, input status, input allocated_address,
                  input used_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bpa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bitmap_page_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit: first-fit physical page allocator
// Keeps one used bit per page in a row-organised RAM and serves allocate
// and free requests one at a time.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on req: action 0 allocates the lowest free page,
// action 1 frees the page at page_address. Every request yields exactly one
// result on rsp with a status, the allocated byte address (zero unless an
// allocation succeeded) and the number of pages in use afterwards.
// After reset the block runs an initialisation pass over all ROWS rows (512 with
// the default geometry), writing one 32-bit bitmap row per cycle so that the
// reserved low pages read as used; req.ready stays low throughout it.
// A free reads the page's row on acceptance, then in S_FREE clears the page's
// bit if it was set and registers the result. An allocation reads the hint row
// on acceptance and then, in S_ALLOC, steps over full rows: the search reads one
// RAM row per cycle, starting at a remembered row below which every row is known
// to be full, and registers the first clear page, or no memory after the last row.
// One request is in flight at a time. A finished result sits in an output
// register; a new request is taken while it waits, but that request cannot
// complete, nor change the bitmap, until the receiver has taken the old one.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit (
  input wire logic  clk,
  input wire logic  rst,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp
);

  localparam logic [bpa_pkg::ROW_W-1:0] LAST_ROW = bpa_pkg::ROW_W'(bpa_pkg::ROWS - 1);

  bpa_pkg::state_t state;
  bpa_pkg::state_t state_next;

  logic [bpa_pkg::ROW_W-1:0]   init_cnt;
  logic [bpa_pkg::ROW_W-1:0]   scan_row;
  logic [bpa_pkg::ROW_W-1:0]   hint;
  logic [bpa_pkg::COUNT_W-1:0] count;
  logic                        free_ok;
  logic [bpa_pkg::PAGE_W-1:0]  free_page;

  logic                           out_valid;
  bpa_pkg::status_t               out_status;
  logic [bpa_pkg::OUT_ADDR_W-1:0] out_addr;
  logic [bpa_pkg::COUNT_W-1:0]    out_count;

  // Bitmap RAM ports.
  logic                         ram_we;
  logic [bpa_pkg::ROW_W-1:0]    ram_waddr;
  logic [bpa_pkg::ROW_BITS-1:0] ram_wdata;
  logic                         ram_re;
  logic [bpa_pkg::ROW_W-1:0]    ram_raddr;
  logic [bpa_pkg::ROW_BITS-1:0] row_data;

  bpa_ram #(
    .WIDTH (bpa_pkg::ROW_BITS),
    .DEPTH (bpa_pkg::ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (row_data)
  );

  // Decode of an incoming free address.
  logic [bpa_pkg::IN_ADDR_W-1:0] req_page_num;
  logic                          req_free_ok;

  assign req_page_num = req.page_address >> bpa_pkg::PAGE_SHIFT;
  assign req_free_ok  = (req.page_address != '0) &&
                        (req.page_address[bpa_pkg::PAGE_SHIFT-1:0] == '0) &&
                        (req_page_num < bpa_pkg::IN_ADDR_W'(bpa_pkg::PAGE_COUNT));

  // Row examination.
  logic                         out_free;
  logic                         row_full;
  logic [bpa_pkg::BIT_W-1:0]    zero_idx;
  logic [bpa_pkg::BIT_W-1:0]    free_bit;
  logic                         was_set;
  logic [bpa_pkg::PAGE_W-1:0]   alloc_page;
  logic [bpa_pkg::PAGE_W+bpa_pkg::PAGE_SHIFT-1:0] alloc_bytes;

  assign out_free    = !out_valid || rsp.ready;
  assign row_full    = &row_data;
  assign zero_idx    = bpa_pkg::first_zero(row_data);
  assign free_bit    = free_page[bpa_pkg::BIT_W-1:0];
  assign was_set     = row_data[free_bit];
  assign alloc_page  = {scan_row, zero_idx};
  assign alloc_bytes = {alloc_page, {bpa_pkg::PAGE_SHIFT{1'b0}}};

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      bpa_pkg::S_INIT: begin
        if (init_cnt == LAST_ROW) state_next = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        if (req.valid) state_next = req.action ? bpa_pkg::S_FREE : bpa_pkg::S_ALLOC;
      end
      bpa_pkg::S_ALLOC: begin
        if ((!row_full || scan_row == LAST_ROW) && out_free) state_next = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_FREE: begin
        if (out_free) state_next = bpa_pkg::S_IDLE;
      end
      default: state_next = bpa_pkg::S_INIT;
    endcase
  end

  // Output and datapath control.
  logic                           finish;
  logic                           advance;
  bpa_pkg::status_t               res_status;
  logic [bpa_pkg::OUT_ADDR_W-1:0] res_addr;
  logic [bpa_pkg::COUNT_W-1:0]    res_count;

  always_comb begin
    req.ready  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    finish     = 1'b0;
    advance    = 1'b0;
    res_status = bpa_pkg::ST_OK;
    res_addr   = '0;
    res_count  = count;
    unique case (state)
      bpa_pkg::S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_cnt;
        ram_wdata = bpa_pkg::init_row(init_cnt);
      end
      bpa_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          ram_re    = 1'b1;
          ram_raddr = req.action ? req_page_num[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W] : hint;
        end
      end
      bpa_pkg::S_ALLOC: begin
        if (!row_full) begin
          if (out_free) begin
            finish    = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = scan_row;
            ram_wdata = row_data | (bpa_pkg::ROW_BITS'(1) << zero_idx);
            res_addr  = bpa_pkg::OUT_ADDR_W'(alloc_bytes);
            res_count = count + 1'b1;
          end
        end else if (scan_row == LAST_ROW) begin
          if (out_free) begin
            finish     = 1'b1;
            res_status = bpa_pkg::ST_NOMEM;
          end
        end else begin
          // Row full: fetch the next one while this one is discarded.
          advance   = 1'b1;
          ram_re    = 1'b1;
          ram_raddr = scan_row + 1'b1;
        end
      end
      bpa_pkg::S_FREE: begin
        if (out_free) begin
          finish = 1'b1;
          if (!free_ok) begin
            res_status = bpa_pkg::ST_BADADDR;
          end else if (was_set) begin
            ram_we    = 1'b1;
            ram_waddr = free_page[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
            ram_wdata = row_data & ~(bpa_pkg::ROW_BITS'(1) << free_bit);
            res_count = count - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpa_pkg::S_INIT;
      init_cnt  <= '0;
      scan_row  <= '0;
      hint      <= bpa_pkg::ROW_W'(bpa_pkg::HINT_ROW);
      count     <= bpa_pkg::COUNT_W'(bpa_pkg::RESERVED_CLIP);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bpa_pkg::S_INIT) begin
        init_cnt <= init_cnt + 1'b1;
      end
      if (state == bpa_pkg::S_IDLE && req.valid) begin
        scan_row  <= hint;
        free_ok   <= req_free_ok;
        free_page <= req_page_num[bpa_pkg::PAGE_W-1:0];
      end
      // Every row below the hint is known to be full.
      if (advance) begin
        scan_row <= scan_row + 1'b1;
        hint     <= scan_row + 1'b1;
      end
      if (state == bpa_pkg::S_FREE && finish && free_ok &&
          free_page[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W] < hint) begin
        hint <= free_page[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
      end
      if (finish) begin
        count      <= res_count;
        out_valid  <= 1'b1;
        out_status <= res_status;
        out_addr   <= res_addr;
        out_count  <= res_count;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.status            = out_status;
  assign rsp.allocated_address = out_addr;
  assign rsp.used_count        = out_count;

  // The controller never reads and writes the same row in one cycle.
  assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("bitmap row read and written in the same cycle");

  // A pending result never gets overwritten.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |-> !finish)
    else $error("result overwritten before it was taken");

  // The reported count matches the live counter until the next completion.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.used_count == count))
    else $error("reported used count differs from counter");

  // Only a successful allocation carries an address.
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != bpa_pkg::ST_OK) |-> (rsp.allocated_address == '0))
    else $error("failed request reports an address");

endmodule
`default_nettype wire
